FILE: src/fsd16_pkg.sv
// Shared types, constants and helpers for the 16-level error diffusion dither.
package fsd16_pkg;

    localparam int PIX_W     = 8;
    localparam int LEVEL_W   = 4;
    localparam int ERR_W     = 16;
    localparam int LW_W      = 12;
    localparam int FH_W      = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 11;
    localparam int ACC_W     = 18;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 12'd1872;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1404;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Q8 weights: 7/16, 5/16, 3/16, 1/16
    localparam logic signed [ACC_W-1:0] WT_RIGHT = 18'sd112;
    localparam logic signed [ACC_W-1:0] WT_BELOW = 18'sd80;
    localparam logic signed [ACC_W-1:0] WT_LLEFT = 18'sd48;
    localparam logic signed [ACC_W-1:0] WT_LRIGHT = 18'sd16;

    localparam logic signed [ACC_W-1:0] ERR_MAX = 18'sd32767;
    localparam logic signed [ACC_W-1:0] ERR_MIN = -18'sd32768;

    // Position flags of one pixel within the frame
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic second_col;
        logic last_col;
        logic next_last;
    } pix_ctl_t;

    function automatic logic signed [ERR_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        begin
            if (v > ERR_MAX)
                r = 16'sh7fff;
            else if (v < ERR_MIN)
                r = 16'sh8000;
            else
                r = v[ERR_W-1:0];
            return r;
        end
    endfunction

endpackage

FILE: src/fsd16_line_mem.sv
// Error line buffer: one write and one registered read per cycle, with write bypass.
module fsd16_line_mem #(
    parameter int DEPTH = fsd16_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(fsd16_pkg::MAX_WIDTH_DEF)
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic signed [fsd16_pkg::ERR_W-1:0]    wdata,
    input  logic                                  re,
    input  logic [AW-1:0]                         raddr,
    output logic signed [fsd16_pkg::ERR_W-1:0]    rdata
);
    import fsd16_pkg::*;

    logic signed [ERR_W-1:0] mem_reg [DEPTH];
    logic signed [ERR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // forward a same-edge write to the read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
                rdata_reg <= wdata;
            else
                rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/fsd16_core.sv
// Quantizer and error spreading for one pixel, with the error carry registers.
module fsd16_core #(
    parameter int XW = $clog2(fsd16_pkg::MAX_WIDTH_DEF)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic [fsd16_pkg::PIX_W-1:0]           pix,
    input  logic [XW-1:0]                         col,
    input  fsd16_pkg::pix_ctl_t                   ctl,
    input  logic signed [fsd16_pkg::ERR_W-1:0]    rd_data,
    output logic [fsd16_pkg::PIX_W-1:0]           res_pixel,
    output logic [fsd16_pkg::LEVEL_W-1:0]         res_level,
    output logic                                  wr_en,
    output logic [XW-1:0]                         wr_addr,
    output logic signed [fsd16_pkg::ERR_W-1:0]    wr_data
);
    import fsd16_pkg::*;

    logic signed [ERR_W-1:0] carry_reg, carry_next;
    logic signed [ERR_W-1:0] nb0_reg, nb0_next;
    logic signed [ERR_W-1:0] nb1_reg, nb1_next;
    logic signed [ERR_W-1:0] head_reg;
    logic signed [ERR_W-1:0] tail_reg;

    logic signed [ERR_W-1:0] this0, this_nx, err, nb0_eff;
    logic signed [SUM_W-1:0] sum, q;
    logic [PIX_W-1:0]        clamped;
    logic [LEVEL_W-1:0]      level;
    logic [PIX_W-1:0]        value;
    logic signed [ACC_W-1:0] q_ext;

    always_comb
    begin
        this0   = ctl.first_row ? '0 : (ctl.last_col ? tail_reg : head_reg);
        this_nx = ctl.first_row ? '0 : (ctl.next_last ? tail_reg : rd_data);
        err     = ctl.first_col ? this0 : carry_reg;

        sum = $signed({3'b000, pix}) + SUM_W'(err >>> 8);
        if (sum < 0)
            clamped = '0;
        else if (sum > 11'sd255)
            clamped = 8'hff;
        else
            clamped = sum[PIX_W-1:0];

        level = clamped[PIX_W-1:PIX_W-LEVEL_W];
        value = {level, level};
        q     = sum - $signed({3'b000, value});
        q_ext = ACC_W'(q);

        nb0_eff    = ctl.first_col ? '0 : nb0_reg;
        carry_next = ctl.last_col ? '0 : sat16(ACC_W'(this_nx) + q_ext * WT_RIGHT);
        wr_data    = sat16(ACC_W'(nb1_reg) + q_ext * WT_LLEFT);
        nb1_next   = sat16(ACC_W'(nb0_eff) + q_ext * WT_BELOW);
        nb0_next   = sat16(q_ext * WT_LRIGHT);

        wr_en   = advance && !ctl.last_row && !ctl.first_col;
        wr_addr = col - XW'(1);

        res_pixel = value;
        res_level = level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            nb0_reg   <= '0;
            nb1_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else if (advance)
        begin
            carry_reg <= carry_next;
            nb0_reg   <= nb0_next;
            nb1_reg   <= nb1_next;
            if (ctl.second_col && !ctl.last_row)
                head_reg <= wr_data;
            if (ctl.last_col && !ctl.last_row)
                tail_reg <= nb1_next;
        end
    end

endmodule

FILE: src/floyd_steinberg_dither_16level_top.sv
// Top level of the 16-level error diffusion dither: handshake, position counters, config.
//
//  channel   | signals                                    | transfer when
//  ----------+--------------------------------------------+------------------------
//  input     | in_valid, in_ready, in_pixel               | in_valid & in_ready
//  result    | out_valid, out_ready, out_pixel,           | out_valid & out_ready
//            | out_level, frame_end                       |
//  config    | cfg_we, cfg_index, cfg_data                | cfg_we
//
// One pixel per cycle sustained while out_ready holds; the result passes through
// the input register, then the result register.
// The single loop is the right-neighbor error carry, closed within the core.
// Reset clears the counters and the config registers to their defaults; the line
// buffer needs no clearing, since the first line of every frame reads zero error.
// A stall on the result side holds both stages; input is still taken while the
// result register drains in the same cycle.
module floyd_steinberg_dither_16level_top #(
    parameter int MAX_WIDTH  = fsd16_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fsd16_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fsd16_pkg::PIX_W-1:0]          in_pixel,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fsd16_pkg::PIX_W-1:0]          out_pixel,
    output logic [fsd16_pkg::LEVEL_W-1:0]        out_level,
    output logic                                 frame_end,
    input  logic                                 cfg_we,
    input  logic [fsd16_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsd16_pkg::CFG_W-1:0]          cfg_data
);
    import fsd16_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration
    logic [LW_W-1:0] line_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [XW-1:0]   wm1;
    logic [YW-1:0]   hm1;

    // position of the next pixel to transfer in
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    pix_ctl_t      acc_ctl;

    // input register
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [XW-1:0]      s1_col_reg;
    pix_ctl_t           s1_ctl_reg;

    // result register
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pixel_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               frame_end_reg;

    logic                    advance;
    logic                    accept;
    logic                    wr_en;
    logic [XW-1:0]           wr_addr;
    logic signed [ERR_W-1:0] wr_data;
    logic signed [ERR_W-1:0] rd_data;
    logic [PIX_W-1:0]        res_pixel;
    logic [LEVEL_W-1:0]      res_level;

    // effective size minus one: zero acts as one, oversize saturates
    always_comb
    begin
        if (line_width_reg == '0)
            wm1 = '0;
        else if (32'(line_width_reg) > 32'(MAX_WIDTH))
            wm1 = XW'(MAX_WIDTH - 1);
        else
            wm1 = XW'(32'(line_width_reg) - 32'd1);

        if (frame_height_reg == '0)
            hm1 = '0;
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            hm1 = YW'(MAX_HEIGHT - 1);
        else
            hm1 = YW'(32'(frame_height_reg) - 32'd1);
    end

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        acc_ctl.first_row  = (row_reg == '0);
        acc_ctl.last_row   = (row_reg >= hm1);
        acc_ctl.first_col  = (col_reg == '0);
        acc_ctl.second_col = ((XW+1)'(col_reg) == (XW+1)'(1));
        acc_ctl.last_col   = (col_reg >= wm1);
        acc_ctl.next_last  = ((XW+1)'(col_reg) + (XW+1)'(1) == (XW+1)'(wm1));

        // advance raster position; wrap at line and frame end
        col_next = col_reg;
        row_next = row_reg;
        if (acc_ctl.last_col)
        begin
            col_next = '0;
            row_next = acc_ctl.last_row ? '0 : row_reg + YW'(1);
        end
        else
        begin
            col_next = col_reg + XW'(1);
        end
    end

    // config registers; any write aborts the frame in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data[LW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default:          line_width_reg   <= line_width_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input register: hold while the core is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= in_pixel;
            s1_col_reg <= col_reg;
            s1_ctl_reg <= acc_ctl;
        end
    end

    // result register: drop valid once transferred, load on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pixel_reg <= res_pixel;
            out_level_reg <= res_level;
            frame_end_reg <= s1_ctl_reg.last_col && s1_ctl_reg.last_row;
        end
    end

    // the right-hand neighbor's error from the line above is fetched as the pixel enters
    fsd16_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (col_reg + XW'(1)),
        .rdata (rd_data)
    );

    fsd16_core #(
        .XW (XW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .pix       (s1_pix_reg),
        .col       (s1_col_reg),
        .ctl       (s1_ctl_reg),
        .rd_data   (rd_data),
        .res_pixel (res_pixel),
        .res_level (res_level),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_level = out_level_reg;
    assign frame_end = frame_end_reg;

endmodule
